[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner: field
// widths, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int DATA_W          = 8;
    localparam int OFFSET_W        = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MASK_W          = 16;
    localparam int LENGTH_W        = 5;
    localparam int PATTERN_W       = 128;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [OFFSET_W-1:0] POSITION_LIMIT = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_WILDCARD     = 2'd2,
        CFG_LENGTH       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } scan_result_t;

endpackage

[rtl/wildcard_byte_pattern_scanner.sv]
// A result passes through the result queue and then the output register to out_valid.
// One byte per cycle while the queue has room; the window compare is in the accept cycle.
// A 2-entry result queue and the output register let input continue while out stalls.
// Reset (rst_n low, asynchronous) clears configuration to defaults, position, match flag
// and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans an image byte stream for the first match of a wildcard byte pattern
// and reports its start offset, or not found at the end of the image.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_W-1:0]     data_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [OFFSET_W-1:0]   match_offset
);

    logic         in_fire;
    logic         push;
    scan_result_t push_res;
    logic         q_full;
    logic         q_nonempty;
    logic         q_pop;
    scan_result_t q_head;

    // Take configuration at any time; accept bytes while the queue has room
    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_fire   = in_valid && in_ready;

    wbps_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_res  (push_res)
    );

    wbps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    wbps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_offset (match_offset)
    );

endmodule

[rtl/wbps_front.sv]
// ----------------------------------------------------------------------------
// wbps_front
// Front part: holds the configuration, shifts accepted bytes into the window,
// compares the window against the pattern and emits one result record per
// found match or per image that ends without one.
// ----------------------------------------------------------------------------
module wbps_front
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_fire,
    input  logic [DATA_W-1:0]     data_byte,
    input  logic                  last_byte,
    output logic                  push,
    output scan_result_t          push_res
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0]     wildcard_reg;
    logic [LENGTH_W-1:0]   length_reg;

    logic [DATA_W-1:0]     window_reg  [PATTERN_MAX];
    logic [DATA_W-1:0]     window_next [PATTERN_MAX];
    logic [OFFSET_W-1:0]   pos_reg;
    logic [OFFSET_W-1:0]   pos_next;
    logic                  reported_reg;
    logic                  reported_next;

    logic [PATTERN_W-1:0]  pattern_all;
    logic [LEN_W-1:0]      used_len;
    logic [OFFSET_W-1:0]   pos_inc;
    logic                  active;
    logic                  window_hit;
    logic                  hit;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            wildcard_reg     <= '0;
            length_reg       <= LENGTH_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                CFG_WILDCARD:     wildcard_reg     <= cfg_data[MASK_W-1:0];
                CFG_LENGTH:       length_reg       <= cfg_data[LENGTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the programmed length into 1 .. PATTERN_MAX
    always_comb
    begin
        if (length_reg == '0)
            used_len = LEN_W'(1);
        else if (length_reg > LENGTH_W'(PATTERN_MAX))
            used_len = LEN_W'(PATTERN_MAX);
        else
            used_len = length_reg[LEN_W-1:0];
    end

    // Shift the new byte in at entry 0
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    // Compare every used non-wildcard pattern byte against its window entry
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        logic [LEN_W-1:0] slot;
        window_hit = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            slot = used_len - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < used_len) && !wildcard_reg[k] &&
                (window_next[slot[IDX_W-1:0]] != pattern_all[k*DATA_W +: DATA_W]))
                window_hit = 1'b0;
        end
    end

    assign pos_inc = pos_reg + OFFSET_W'(1);
    assign active  = !reported_reg && (pos_reg != POSITION_LIMIT);
    assign hit     = active && (pos_inc >= OFFSET_W'(used_len)) && window_hit;

    // Emit a result on a match or on an image end without one
    always_comb
    begin
        push            = in_fire && (hit || (last_byte && !reported_reg));
        push_res.found  = hit;
        push_res.offset = hit ? (pos_inc - OFFSET_W'(used_len)) : '0;
    end

    // Advance position and match flag; restart after the final byte
    always_comb
    begin
        pos_next      = pos_reg;
        reported_next = reported_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else if (active)
            begin
                pos_next      = pos_inc;
                reported_next = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
        end
    end

    // Hold the window; stale entries are never compared since a match
    // needs at least the pattern length of fresh bytes
    always_ff @(posedge clk)
    begin
        if (in_fire && active)
            window_reg <= window_next;
    end

endmodule

[rtl/wbps_queue.sv]
// ----------------------------------------------------------------------------
// wbps_queue
// Short result queue between the front and back parts, so that either side
// can stall on its own.
// ----------------------------------------------------------------------------
module wbps_queue
    import wbps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scan_result_t push_res,
    input  logic         pop,
    output logic         full,
    output logic         nonempty,
    output scan_result_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scan_result_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_res;
    end

endmodule

[rtl/wbps_back.sv]
// ----------------------------------------------------------------------------
// wbps_back
// Back part: moves result records from the queue into the output register
// and presents them on the output channel until each transfer completes.
// ----------------------------------------------------------------------------
module wbps_back
    import wbps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  scan_result_t        q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [OFFSET_W-1:0] match_offset
);

    logic         valid_reg;
    logic         valid_next;
    scan_result_t res_reg;

    // Load when the output register is empty or its transfer completes
    assign q_pop = q_nonempty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= q_head;
    end

    assign out_valid    = valid_reg;
    assign found        = res_reg.found;
    assign match_offset = res_reg.offset;

endmodule

[rtl/wbps_checker.sv]
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the scanner's output channel and result timing,
// attached to the top level by a bind.
// ----------------------------------------------------------------------------
module wbps_checker
    import wbps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                found,
    input  logic [OFFSET_W-1:0] match_offset
);

    // Hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(match_offset));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    // A not-found result carries a zero offset
    property p_not_found_zero;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !found) |-> (match_offset == '0);
    endproperty
    a_not_found_zero: assert property (p_not_found_zero)
        else $error("not-found result with nonzero offset");

    // A result rising on idle output follows an input transfer, queued and registered
    property p_result_cause;
        @(posedge clk) disable iff (!rst_n)
            $rose(out_valid) |-> $past(in_valid && in_ready, 2);
    endproperty
    a_result_cause: assert property (p_result_cause)
        else $error("result without a causing input transfer");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset)
);

[verif/wildcard_byte_pattern_scanner_test.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_test
// Self-checking bench for the wildcard byte pattern scanner. Streams images
// made of embedded, broken and random patterns under several register
// settings. Every accepted byte feeds a scan predictor that holds the
// expected reports in order, and every report that leaves the block is
// compared against it. Both sides stall at random, and the output is held
// off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_test;
    import wbps_pkg::*;

    // Predict scan reports and check the ones the block delivers
    class match_tracker;
        logic [CFG_DATA_W-1:0] pattern_lo;
        logic [CFG_DATA_W-1:0] pattern_hi;
        logic [MASK_W-1:0]     wild_bits;
        logic [LENGTH_W-1:0]   length_reg;
        logic [DATA_W-1:0]     window [16];
        logic [OFFSET_W-1:0]   position;
        bit                    reported;
        scan_result_t          pending_reports [$];
        int                    errors;

        function new();
            pattern_lo = '0;
            pattern_hi = '0;
            wild_bits  = '0;
            length_reg = LENGTH_W'(1);
            errors     = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i])
                window[i] = '0;
            position = '0;
            reported = 1'b0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_LOW:  pattern_lo = value;
                CFG_PATTERN_HIGH: pattern_hi = value;
                CFG_WILDCARD:     wild_bits  = value[MASK_W-1:0];
                CFG_LENGTH:       length_reg = value[LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp the length register to the range the scanner honors
        function int active_length();
            int n;
            n = length_reg;
            if (n == 0)
                n = 1;
            if (n > PATTERN_MAX_DEF)
                n = PATTERN_MAX_DEF;
            return n;
        endfunction

        function logic [DATA_W-1:0] pattern_at(int k);
            if (k < 8)
                return pattern_lo[k*8 +: 8];
            return pattern_hi[(k-8)*8 +: 8];
        endfunction

        // Oldest byte in the window lines up with pattern byte 0
        function bit window_hit(int n);
            int k;
            for (k = 0; k < n; k++)
                if (!wild_bits[k] && window[n-1-k] != pattern_at(k))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void take_byte(logic [DATA_W-1:0] data, logic is_last);
            int           n;
            int           i;
            scan_result_t r;
            if (!reported && position != POSITION_LIMIT) begin
                n = active_length();
                for (i = 15; i > 0; i--)
                    window[i] = window[i-1];
                window[0] = data;
                position  = position + 1;
                if (position >= OFFSET_W'(n) && window_hit(n)) begin
                    reported = 1'b1;
                    r.found  = 1'b1;
                    r.offset = position - OFFSET_W'(n);
                    pending_reports = {pending_reports, r};
                end
            end
            // End of image: report not found unless matched, then start over
            if (is_last) begin
                if (!reported) begin
                    r.found  = 1'b0;
                    r.offset = '0;
                    pending_reports = {pending_reports, r};
                end
                clear_scan();
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_report(logic got_found, logic [OFFSET_W-1:0] got_offset);
            scan_result_t want;
            if (pending_reports.size() == 0) begin
                note_error($sformatf("unexpected report found=%0b offset=%0d",
                                     got_found, got_offset));
                return;
            end
            want = pending_reports.pop_front();
            if (got_found !== want.found || got_offset !== want.offset)
                note_error($sformatf("expected found=%0b offset=%0d, got found=%0b offset=%0d",
                                     want.found, want.offset, got_found, got_offset));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     data_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [OFFSET_W-1:0]   match_offset;

    match_tracker tracker;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int bytes_sent = 0;

    wildcard_byte_pattern_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_offset (match_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive out_ready; a requested hold-off overrides random stalls
    always @(negedge clk)
    begin
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end
        else begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every report transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_report(found, match_offset);
    end

    initial
    begin
        #2000000;
        $display("wildcard_byte_pattern_scanner regression: fail");
        $finish;
    end

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_byte(logic [DATA_W-1:0] value, logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = value;
        last_byte = is_last;
        do @(posedge clk); while (!in_ready);
        tracker.take_byte(value, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Wait for all reports, then let the pipeline empty
    task automatic settle();
        in_valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] noise_byte();
        case ($urandom_range(3))
            0: return tracker.pattern_at($urandom_range(15));
            1: return 8'h00;
            2: return 8'hFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Build one image: embedded pattern, broken pattern, or noise
    task automatic send_image();
        logic [DATA_W-1:0] img [$];
        logic [DATA_W-1:0] b;
        int n;
        int kind;
        int cut;
        int flip;
        int k;
        n    = tracker.active_length();
        kind = $urandom_range(99);
        if (kind < 80) begin
            repeat ($urandom_range(8)) img = {img, noise_byte()};
            cut  = n;
            flip = -1;
            if (kind >= 62) begin
                if ($urandom_range(1) && n > 1)
                    cut = $urandom_range(n - 1, 1);
                else
                    flip = $urandom_range(n - 1);
            end
            for (k = 0; k < cut; k++) begin
                b = tracker.wild_bits[k] ? DATA_W'($urandom) : tracker.pattern_at(k);
                if (k == flip)
                    b = b ^ DATA_W'(1 << $urandom_range(7));
                img = {img, b};
            end
            repeat ($urandom_range(6)) img = {img, noise_byte()};
        end
        else begin
            repeat ($urandom_range(24, 1)) img = {img, noise_byte()};
        end
        foreach (img[i])
            send_byte(img[i], i == img.size() - 1);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit squeeze);
        int blk;
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (blk = 0; blk < 6; blk++) begin
            settle();
            case (blk)
                0: begin
                    write_register(CFG_PATTERN_LOW, {$urandom, $urandom});
                    write_register(CFG_PATTERN_HIGH, {$urandom, $urandom});
                    write_register(CFG_WILDCARD, '0);
                    write_register(CFG_LENGTH, CFG_DATA_W'(16));
                end
                1: begin
                    write_register(CFG_PATTERN_LOW, '0);
                    write_register(CFG_PATTERN_HIGH, '0);
                    write_register(CFG_WILDCARD, '0);
                    write_register(CFG_LENGTH, CFG_DATA_W'(1));
                end
                2: begin
                    write_register(CFG_PATTERN_LOW, '1);
                    write_register(CFG_PATTERN_HIGH, '1);
                    write_register(CFG_WILDCARD, CFG_DATA_W'(16'hFFFF));
                    write_register(CFG_LENGTH, CFG_DATA_W'($urandom_range(31, 17)));
                end
                3: begin
                    write_register(CFG_PATTERN_LOW, {$urandom, $urandom});
                    write_register(CFG_PATTERN_HIGH, {$urandom, $urandom});
                    write_register(CFG_WILDCARD, CFG_DATA_W'($urandom_range(16'hFFFF)));
                    write_register(CFG_LENGTH, '0);
                end
                default: begin
                    write_register(CFG_PATTERN_LOW, {$urandom, $urandom});
                    write_register(CFG_PATTERN_HIGH, {$urandom, $urandom});
                    write_register(CFG_WILDCARD, CFG_DATA_W'($urandom_range(16'hFFFF)));
                    write_register(CFG_LENGTH, CFG_DATA_W'($urandom_range(31)));
                end
            endcase
            // Stall the output for a long stretch while bytes keep coming
            if (squeeze && blk == 0)
                hold_requests++;
            target = bytes_sent + 88;
            while (bytes_sent < target)
                send_image();
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 55;
        write_register(CFG_PATTERN_LOW, 64'h0000_0000_00CC_00AA);
        write_register(CFG_PATTERN_HIGH, {$urandom, $urandom});
        write_register(CFG_WILDCARD, CFG_DATA_W'(16'h0002));
        write_register(CFG_LENGTH, CFG_DATA_W'(3));

        // Match that ends on the final byte of the image
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hCC, 1'b1);

        // Bytes after a match report nothing, the final one included
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Shorten the pattern in the middle of an image
        send_byte(8'hAA, 1'b0);
        settle();
        write_register(CFG_LENGTH, CFG_DATA_W'(2));
        send_byte(8'h77, 1'b1);

        // Zero length acts as a single byte
        settle();
        write_register(CFG_WILDCARD, '0);
        write_register(CFG_LENGTH, '0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b1);

        // Oversized length clamps to sixteen, all wildcards
        settle();
        write_register(CFG_WILDCARD, CFG_DATA_W'(16'hFFFF));
        write_register(CFG_LENGTH, CFG_DATA_W'(31));
        for (int i = 0; i < 16; i++)
            send_byte((i % 2) ? 8'hFF : 8'h00, i == 15);

        run_phase(7, 55, 1'b0);
        run_phase(55, 7, 1'b0);
        run_phase(0, 0, 1'b1);

        settle();
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("wildcard_byte_pattern_scanner regression: pass");
        else
            $display("wildcard_byte_pattern_scanner regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/wbps_pkg.sv
rtl/wbps_front.sv
rtl/wbps_queue.sv
rtl/wbps_back.sv
rtl/wildcard_byte_pattern_scanner.sv
rtl/wbps_checker.sv
verif/wildcard_byte_pattern_scanner_test.sv
